// ===== sv/flac_fixed_rice_residual_coder_defines.svh =====
// Assertion macros used by the coder's top module.
`ifndef FLAC_FIXED_RICE_RESIDUAL_CODER_DEFINES_SVH
`define FLAC_FIXED_RICE_RESIDUAL_CODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ffrc_pkg.sv =====
package ffrc_pkg;

  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned RICE_W       = 4;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned SBITS_W      = 6;
  localparam int unsigned ORDER_W      = 3;
  localparam int unsigned MAX_QUOTIENT = 4032;
  localparam int unsigned CHUNK_BITS   = 64;
  localparam int unsigned QUOT_W       = $clog2(MAX_QUOTIENT + 1);
  localparam int unsigned ORDER_CAP    = 4;
  localparam int unsigned MAX_RICE     = 14;
  localparam int unsigned MIN_SBITS    = 4;
  localparam int unsigned MAX_SBITS    = 32;
  localparam int unsigned SBITS_RESET  = 16;

  // Register indexes on the config port.
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_SBITS = 1'b1;

  // Work handed from the front end to the emitter.
  typedef struct packed {
    logic                  warm;   // verbatim warmup sample
    logic [SAMPLE_W-1:0]   value;  // masked sample, or raw residual
    logic [SBITS_W-1:0]    width;  // verbatim width
    logic [RICE_W-1:0]     k;      // Rice parameter
  } ffrc_job_t;

endpackage

// ===== sv/flac_fixed_rice_residual_coder.sv =====
// Fixed-predictor residual coder with Rice output chunks.
//
// Input stream (s_axis): one audio sample per request. tuser flags the first
// sample of a block, which restarts the warmup. The first predictor_order
// samples of a block (at most 4) come out verbatim as one chunk of sample_bits
// bits (held to 4..32); all later ones are residuals of that order's fixed predictor.
// Output stream (m_axis): chunks of code bits, right aligned, most significant
// bit sent first. A residual gives zero or more all-zero unary chunks of up to
// 64 bits, then a final chunk (tlast high) with the stop bit and remainder.
// tuser marks every chunk of a sample whose quotient was cut to 4032.
// Config port: index 0 is predictor_order, index 1 is sample_bits; always
// ready. It must be written only while the coder is idle; the coder does not enforce this.
// Timing: a front end accepts and computes the residual in the accept cycle
// and pushes it to a two-entry queue; the emitter loads a queue entry while
// idle and then sends one chunk per cycle while the output slot is free. It
// takes a new entry only after the last sample's final chunk is registered.
// Reset clears history, warmup count, queue and output register, and returns
// predictor_order to 0 and sample_bits to 16. A stalled receiver holds the
// output register; the queue then fills and s_axis_tready drops.
module flac_fixed_rice_residual_coder #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input request.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] sample, [35:32] Rice k, [39:36] zero
  input  logic        s_axis_tuser,   // [0] block_start
  // Output chunk.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] bits, [38:32] bit_count, [39] zero
  output logic        m_axis_tlast,   // last chunk of the sample
  output logic        m_axis_tuser,   // [0] overflow
  // Register writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import ffrc_pkg::*;

  `include "flac_fixed_rice_residual_coder_defines.svh"

  ffrc_job_t push_job, pop_job;
  logic      push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  // Accept, track history and warmup, compute the residual.
  ffrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_o        (push),
    .job_o         (push_job),
    .full_i        (full)
  );

  // Decouple the front end from the emitter.
  ffrc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // Map, split and send the chunks.
  ffrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .job_i         (pop_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Unary chunks carry only zeros and a nonzero count.
  `FFRC_ASSERT_NOW(a_unary_zero, m_axis_tvalid && !m_axis_tlast, (m_axis_tdata[31:0] == '0) && (m_axis_tdata[38:32] != '0) && (m_axis_tdata[38:32] <= 7'(CHUNK_BITS)), "unary chunk malformed")
  // Overflow is only possible on a Rice code, whose final chunk is k + 1 bits.
  `FFRC_ASSERT_NOW(a_ovf_len, m_axis_tvalid && m_axis_tlast && m_axis_tuser, m_axis_tdata[38:32] <= 7'(MAX_RICE + 1), "overflow on a chunk that is not a Rice code")
  // A taken unary chunk is always followed at once by the next chunk of the sample.
  `FFRC_ASSERT_NEXT(a_unary_follow, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "no chunk after a taken unary chunk")

endmodule

// ===== sv/ffrc_fifo.sv =====
module ffrc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ffrc_pkg::ffrc_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output ffrc_pkg::ffrc_job_t pop_data_o,
  output logic              empty_o
);
  import ffrc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ffrc_job_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/ffrc_front.sv =====
module ffrc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [39:0]               s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_index_i,
  input  logic [ffrc_pkg::SBITS_W-1:0] cfg_data_i,
  output logic                      push_o,
  output ffrc_pkg::ffrc_job_t       job_o,
  input  logic                      full_i
);
  import ffrc_pkg::*;

  logic [ORDER_W-1:0]  order_q;
  logic [SBITS_W-1:0]  sbits_q;
  logic [SAMPLE_W-1:0] hist_q [4];
  logic [ORDER_W-1:0]  warm_cnt_q, warm_cnt_d;

  logic [SAMPLE_W-1:0] sample, resid, mask;
  logic [RICE_W-1:0]   k_raw, k_eff;
  logic [ORDER_W-1:0]  order_eff, cnt_eff;
  logic [SBITS_W-1:0]  width_eff;
  logic                warm;

  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;
  assign sample        = s_axis_tdata[SAMPLE_W-1:0];
  assign k_raw         = s_axis_tdata[SAMPLE_W +: RICE_W];

  always_comb begin
    order_eff = (order_q > ORDER_W'(ORDER_CAP)) ? ORDER_W'(ORDER_CAP) : order_q;
    if (sbits_q < SBITS_W'(MIN_SBITS)) begin
      width_eff = SBITS_W'(MIN_SBITS);
    end else if (sbits_q > SBITS_W'(MAX_SBITS)) begin
      width_eff = SBITS_W'(MAX_SBITS);
    end else begin
      width_eff = sbits_q;
    end
    k_eff   = (k_raw > RICE_W'(MAX_RICE)) ? RICE_W'(MAX_RICE) : k_raw;
    cnt_eff = s_axis_tuser ? '0 : warm_cnt_q;
    warm    = (cnt_eff < order_eff);
    warm_cnt_d = warm ? cnt_eff + 1'b1 : cnt_eff;
    // A shift of 32 empties the word, so full width keeps every bit.
    mask = ~({SAMPLE_W{1'b1}} << width_eff);
  end

  // Fixed predictor taps as shifts and adds, wrapping to the sample width.
  always_comb begin
    case (order_eff)
      3'd0: resid = sample;
      3'd1: resid = sample - hist_q[0];
      3'd2: resid = sample - (hist_q[0] << 1) + hist_q[1];
      3'd3: resid = sample - ((hist_q[0] << 1) + hist_q[0])
                  + ((hist_q[1] << 1) + hist_q[1]) - hist_q[2];
      default: resid = sample - (hist_q[0] << 2) + (hist_q[1] << 2) + (hist_q[1] << 1)
                     - (hist_q[2] << 2) + hist_q[3];
    endcase
  end

  always_comb begin
    job_o.warm  = warm;
    job_o.value = warm ? (sample & mask) : resid;
    job_o.width = width_eff;
    job_o.k     = k_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q    <= '0;
      sbits_q    <= SBITS_W'(SBITS_RESET);
      warm_cnt_q <= '0;
      for (int i = 0; i < 4; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ORDER: order_q <= cfg_data_i[ORDER_W-1:0];
          REG_SBITS: sbits_q <= cfg_data_i;
          default:   order_q <= order_q;
        endcase
      end
      if (push_o) begin
        warm_cnt_q <= warm_cnt_d;
        hist_q[3]  <= hist_q[2];
        hist_q[2]  <= hist_q[1];
        hist_q[1]  <= hist_q[0];
        hist_q[0]  <= sample;
      end
    end
  end

endmodule

// ===== sv/ffrc_back.sv =====
module ffrc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  ffrc_pkg::ffrc_job_t job_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  output logic                m_axis_tuser
);
  import ffrc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e              state_q;
  logic [QUOT_W-1:0]   quot_q;
  logic [SAMPLE_W-1:0] code_q;
  logic [COUNT_W-1:0]  len_q;
  logic                ovf_q;
  logic                out_valid_q, out_last_q, out_ovf_q;
  logic [SAMPLE_W-1:0] out_bits_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic [SAMPLE_W-1:0] zz, shifted, rmask;
  logic                over;
  logic                slot_free;
  logic [QUOT_W-1:0]   chunk;

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    zz      = {job_i.value[SAMPLE_W-2:0], 1'b0} ^ {SAMPLE_W{job_i.value[SAMPLE_W-1]}};
    shifted = zz >> job_i.k;
    over    = (shifted > SAMPLE_W'(MAX_QUOTIENT));
    rmask   = ~({SAMPLE_W{1'b1}} << job_i.k);
    chunk   = (quot_q < QUOT_W'(CHUNK_BITS)) ? quot_q : QUOT_W'(CHUNK_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      quot_q      <= '0;
      code_q      <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_bits_q  <= '0;
      out_count_q <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          // Drop the output chunk once taken.
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
          end
          if (!empty_i) begin
            state_q <= ST_RUN;
            if (job_i.warm) begin
              quot_q <= '0;
              code_q <= job_i.value;
              len_q  <= COUNT_W'(job_i.width);
              ovf_q  <= 1'b0;
            end else begin
              quot_q <= over ? QUOT_W'(MAX_QUOTIENT) : shifted[QUOT_W-1:0];
              code_q <= (zz & rmask) | (SAMPLE_W'(1) << job_i.k);
              len_q  <= COUNT_W'(job_i.k) + 1'b1;
              ovf_q  <= over;
            end
          end
        end
        ST_RUN: begin
          // Hold the output chunk until the slot frees up.
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_ovf_q   <= ovf_q;
            if (quot_q != '0) begin
              // Unary run: up to one chunk of zeros per cycle while the slot is free.
              out_bits_q  <= '0;
              out_count_q <= COUNT_W'(chunk);
              out_last_q  <= 1'b0;
              quot_q      <= quot_q - chunk;
            end else begin
              out_bits_q  <= code_q;
              out_count_q <= len_q;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, out_bits_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule
